// File: hdl/pci_pkg.sv
// Shared types and constants of the pad charge integrator.
// No dependencies; every other file imports this package.
package pci_pkg;

    // Fixed field widths
    localparam int ACC_BITS       = 20;
    localparam int ROW_BITS       = 8;
    localparam int PAD_BITS       = 8;
    localparam int OFF_BITS       = 9;
    localparam int COL_BITS       = 10;
    localparam int WIN_BITS       = 10;
    localparam int COLOR_BITS     = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;

    // Job queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // Palette scaling: color_count * (level - threshold), quotient below 2^8
    localparam int QUO_BITS  = COLOR_BITS;
    localparam int STEP_BITS = 3;
    localparam int NUM_BITS  = ACC_BITS + COLOR_BITS;

    localparam logic [ACC_BITS-1:0] ACC_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW_START    = 3'd0,
        CFG_WINDOW_END      = 3'd1,
        CFG_PEAK_MODE       = 3'd2,
        CFG_LEVEL_LIMIT     = 3'd3,
        CFG_LEVEL_THRESHOLD = 3'd4,
        CFG_COLOR_COUNT     = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [WIN_BITS-1:0]   window_start;
        logic [WIN_BITS-1:0]   window_end;
        logic                  peak_mode;
        logic [ACC_BITS-1:0]   level_limit;
        logic [ACC_BITS-1:0]   level_threshold;
        logic [COLOR_BITS-1:0] color_count;
    } t_cfg;

    // One finished pad, handed from front to back
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] column;
        logic [ACC_BITS-1:0] acc;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCALE,
        B_DIVIDE,
        B_CAP,
        B_SEND
    } t_back_state;

endpackage

// File: hdl/pci_if.sv
// Valid/ready channels of the pad charge integrator: samples in, results out.
// Depends on pci_pkg for the fixed field widths.
interface pci_sample_if #(
    parameter int TIME_BITS  = 10,
    parameter int VALUE_BITS = 10
);
    import pci_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TIME_BITS-1:0]  time_bin;
    logic [PAD_BITS-1:0]   pad_index;
    logic [VALUE_BITS-1:0] sample_value;
    logic [ROW_BITS-1:0]   row_index;
    logic [OFF_BITS-1:0]   column_offset;
    logic                  pad_done;

    modport source (
        output valid, time_bin, pad_index, sample_value, row_index, column_offset, pad_done,
        input  ready
    );
    modport sink (
        input  valid, time_bin, pad_index, sample_value, row_index, column_offset, pad_done,
        output ready
    );
endinterface

interface pci_result_if;
    import pci_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROW_BITS-1:0]   out_row;
    logic [COL_BITS-1:0]   out_column;
    logic [ACC_BITS-1:0]   pad_level;
    logic [COLOR_BITS-1:0] palette_index;

    modport source (
        output valid, out_row, out_column, pad_level, palette_index,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_column, pad_level, palette_index,
        output ready
    );
endinterface

// File: hdl/pad_charge_integrator_core.sv
// Pad charge integrator: one sample accepted per cycle while the job queue has room.
// A pad whose level exceeds the threshold passes a clamp/compare, one multiply,
// 8 divider steps and a cap step before its result is offered. The back end takes
// no new pad until the last one is sent or dropped; a dropped pad skips the divider;
// the 4-entry job queue absorbs bursts of short pads.
// Synchronous active-low reset clears the accumulator, queue pointers, back-end state and registers.
module pad_charge_integrator_core #(
    parameter int VALUE_BITS = 10,
    parameter int TIME_BITS  = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pci_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [pci_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata,
    pci_sample_if.sink                          i_sample,
    pci_result_if.source                        o_result
);
    import pci_pkg::*;

    t_cfg          r_cfg;
    t_job          push_job;
    t_job          head_job;
    t_queue_status queue_status;
    logic          push;
    logic          pop;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_start    <= WIN_BITS'(0);
            r_cfg.window_end      <= WIN_BITS'(1023);
            r_cfg.peak_mode       <= 1'b0;
            r_cfg.level_limit     <= ACC_BITS'(1023);
            r_cfg.level_threshold <= ACC_BITS'(0);
            r_cfg.color_count     <= COLOR_BITS'(50);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_WINDOW_START:    r_cfg.window_start    <= i_cfg_wdata[WIN_BITS-1:0];
                CFG_WINDOW_END:      r_cfg.window_end      <= i_cfg_wdata[WIN_BITS-1:0];
                CFG_PEAK_MODE:       r_cfg.peak_mode       <= i_cfg_wdata[0];
                CFG_LEVEL_LIMIT:     r_cfg.level_limit     <= i_cfg_wdata[ACC_BITS-1:0];
                CFG_LEVEL_THRESHOLD: r_cfg.level_threshold <= i_cfg_wdata[ACC_BITS-1:0];
                CFG_COLOR_COUNT:     r_cfg.color_count     <= i_cfg_wdata[COLOR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    pci_front #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_sample (i_sample),
        .i_queue  (queue_status),
        .o_push   (push),
        .o_job    (push_job)
    );

    pci_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (queue_status)
    );

    pci_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (head_job),
        .i_queue  (queue_status),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

// File: hdl/pci_front.sv
// Front end: accepts samples, keeps the pad accumulator, pushes finished pads.
// Depends on pci_pkg and pci_sample_if.
module pci_front #(
    parameter int TIME_BITS  = 10,
    parameter int VALUE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pci_pkg::t_cfg         i_cfg,
    pci_sample_if.sink            i_sample,
    input  pci_pkg::t_queue_status i_queue,
    output logic                  o_push,
    output pci_pkg::t_job         o_job
);
    import pci_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > WIN_BITS) ? TIME_BITS : WIN_BITS;

    logic [ACC_BITS-1:0]   r_acc;
    logic [ACC_BITS-1:0]   n_acc;
    logic [ACC_BITS-1:0]   acc_step;
    logic [CMP_BITS-1:0]   t_ext;
    logic [CMP_BITS-1:0]   start_ext;
    logic [CMP_BITS-1:0]   end_ext;
    logic                  in_window;
    logic                  half_edge;
    logic [VALUE_BITS-1:0] addend;
    logic [ACC_BITS:0]     sum;
    logic                  accept;

    assign i_sample.ready = !i_queue.full;
    assign accept         = i_sample.valid && !i_queue.full;

    // Window test; edge bins count half when the span is even
    assign t_ext     = CMP_BITS'(i_sample.time_bin);
    assign start_ext = CMP_BITS'(i_cfg.window_start);
    assign end_ext   = CMP_BITS'(i_cfg.window_end);
    assign in_window = (t_ext >= start_ext) && (t_ext <= end_ext);
    assign half_edge = (i_cfg.window_end[0] == i_cfg.window_start[0])
                       && ((t_ext == start_ext) || (t_ext == end_ext));
    assign addend    = half_edge ? (i_sample.sample_value >> 1) : i_sample.sample_value;
    assign sum       = {1'b0, r_acc} + (ACC_BITS+1)'(addend);

    // Fold the sample into the accumulator
    always_comb begin
        if (i_cfg.peak_mode) begin
            acc_step = (ACC_BITS'(i_sample.sample_value) > r_acc)
                       ? ACC_BITS'(i_sample.sample_value) : r_acc;
        end else if (in_window) begin
            acc_step = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
        end else begin
            acc_step = r_acc;
        end
    end

    // Clear after the last sample of a pad
    always_comb begin
        n_acc = r_acc;
        if (accept) begin
            n_acc = i_sample.pad_done ? '0 : acc_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Hand the finished pad to the queue
    assign o_push        = accept && i_sample.pad_done;
    assign o_job.row     = i_sample.row_index;
    assign o_job.column  = COL_BITS'(i_sample.pad_index) + COL_BITS'(i_sample.column_offset);
    assign o_job.acc     = acc_step;

endmodule

// File: hdl/pci_queue.sv
// Short job queue that decouples the sample front end from the scaling back end.
// Depends on pci_pkg.
module pci_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pci_pkg::t_job          i_job,
    input  logic                   i_pop,
    output pci_pkg::t_job          o_job,
    output pci_pkg::t_queue_status o_status
);
    import pci_pkg::*;

    t_job                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_status.full  = (r_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hdl/pci_back.sv
// Back end: clamps each pad level, drops it at or below threshold, else scales it
// to a palette index with a bit-serial divider. Depends on pci_pkg, pci_result_if.
module pci_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pci_pkg::t_cfg          i_cfg,
    input  pci_pkg::t_job          i_job,
    input  pci_pkg::t_queue_status i_queue,
    output logic                   o_pop,
    pci_result_if.source           o_result
);
    import pci_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [STEP_BITS-1:0]  r_step;
    logic [ROW_BITS-1:0]   r_row;
    logic [COL_BITS-1:0]   r_col;
    logic [ACC_BITS-1:0]   r_level;
    logic                  r_emit;
    logic [ACC_BITS-1:0]   r_den;
    logic [ACC_BITS-1:0]   r_rem;
    logic [QUO_BITS-1:0]   r_quo;
    logic [COLOR_BITS-1:0] r_pal;

    logic [ACC_BITS-1:0]   level;
    logic [NUM_BITS-1:0]   product;
    logic [ACC_BITS:0]     trial;
    logic [ACC_BITS:0]     diff;
    logic                  fits;

    // Clamp to the limit
    assign level   = (i_job.acc < i_cfg.level_limit) ? i_job.acc : i_cfg.level_limit;
    // Numerator; quotient never exceeds color_count since level <= limit
    assign product = NUM_BITS'(i_cfg.color_count)
                     * NUM_BITS'(r_level - i_cfg.level_threshold);
    // One restoring division step
    assign trial   = {r_rem, r_quo[QUO_BITS-1]};
    assign diff    = trial - {1'b0, r_den};
    assign fits    = (trial >= {1'b0, r_den});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_queue.empty) begin
                    n_state = B_SCALE;
                end
            end
            B_SCALE: begin
                n_state = r_emit ? B_DIVIDE : B_IDLE;
            end
            B_DIVIDE: begin
                if (r_step == STEP_BITS'(QUO_BITS - 1)) begin
                    n_state = B_CAP;
                end
            end
            B_CAP: begin
                n_state = B_SEND;
            end
            B_SEND: begin
                if (o_result.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_pop          = (r_state == B_IDLE) && !i_queue.empty;
        o_result.valid = (r_state == B_SEND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DIVIDE) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_row   <= i_job.row;
                r_col   <= i_job.column;
                r_level <= level;
                r_emit  <= (level > i_cfg.level_threshold);
            end
            B_SCALE: begin
                r_den <= i_cfg.level_limit - i_cfg.level_threshold;
                r_rem <= product[NUM_BITS-1:QUO_BITS];
                r_quo <= product[QUO_BITS-1:0];
            end
            B_DIVIDE: begin
                r_rem <= fits ? diff[ACC_BITS-1:0] : trial[ACC_BITS-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], fits};
            end
            B_CAP: begin
                // Top of the scale maps to the last palette entry
                if ((i_cfg.color_count != '0) && (r_quo >= i_cfg.color_count)) begin
                    r_pal <= i_cfg.color_count - 1'b1;
                end else begin
                    r_pal <= r_quo;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.out_row       = r_row;
    assign o_result.out_column    = r_col;
    assign o_result.pad_level     = r_level;
    assign o_result.palette_index = r_pal;

endmodule

// File: hdl/pci_checker.sv
// Port-level checks on the result channel of the pad charge integrator.
// Depends on pci_pkg; bound to pad_charge_integrator_core below.
module pci_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_res_valid,
    input logic                             i_res_ready,
    input logic [pci_pkg::ACC_BITS-1:0]     i_res_level,
    input logic [pci_pkg::COLOR_BITS-1:0]   i_res_palette
);
    import pci_pkg::*;

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // Hold a stalled result
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // Only levels above the threshold are emitted, so never zero
    a_level_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_level != '0))
        else $error("zero level emitted");

    // Palette index is capped below the largest color count
    a_palette_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_palette != '1))
        else $error("palette index out of range");

endmodule

bind pad_charge_integrator_core pci_checker u_pci_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_res_valid   (o_result.valid),
    .i_res_ready   (o_result.ready),
    .i_res_level   (o_result.pad_level),
    .i_res_palette (o_result.palette_index)
);

// File: tb/pad_charge_integrator_core_test.sv
// Self-checking testbench for pad_charge_integrator_core: drives samples over the valid/ready
// channel, predicts each pad's level and palette index, and checks every result in order.
// Depends on pci_pkg, pci_sample_if, pci_result_if and the core itself.
module pad_charge_integrator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pci_pkg::*;

    localparam int TIME_BITS       = 10;
    localparam int VALUE_BITS      = 10;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int HOLD_OFF_AFTER  = 60;
    localparam int PRINT_LIMIT     = 40;

    typedef struct packed {
        logic [TIME_BITS-1:0]  time_bin;
        logic [PAD_BITS-1:0]   pad_index;
        logic [VALUE_BITS-1:0] sample_value;
        logic [ROW_BITS-1:0]   row_index;
        logic [OFF_BITS-1:0]   column_offset;
        logic                  pad_done;
    } t_sample;

    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   column;
        logic [ACC_BITS-1:0]   level;
        logic [COLOR_BITS-1:0] palette;
    } t_pad_result;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE
    } t_stall;

    logic i_clk;
    logic i_rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    pci_sample_if #(.TIME_BITS(TIME_BITS), .VALUE_BITS(VALUE_BITS)) sample_ch ();
    pci_result_if result_ch ();

    pad_charge_integrator_core #(
        .VALUE_BITS(VALUE_BITS),
        .TIME_BITS (TIME_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_sample   (sample_ch),
        .o_result   (result_ch)
    );

    // Predictor state: register copy and the running pad accumulator
    t_cfg                cfg_shadow;
    logic [ACC_BITS-1:0] pad_acc_model;

    t_sample     pending_samples[$];
    t_pad_result pad_results_due[$];
    int          offered_total;
    int          accepted_total;
    int          error_count;

    // Sender and receiver pacing
    t_sample     offer;
    bit          offer_emits;
    t_pad_result offer_result;
    t_pad_result next_due;
    int          burst_left;
    int          gap_left;
    t_stall      stall_mode;
    int          mode_left;
    int          stall_phase;
    logic        hold_off;

    // Free-running clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Drive every input to a known value, hold reset, then release it
    initial begin
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.time_bin      = '0;
        sample_ch.pad_index     = '0;
        sample_ch.sample_value  = '0;
        sample_ch.row_index     = '0;
        sample_ch.column_offset = '0;
        sample_ch.pad_done      = 1'b0;
        result_ch.ready         = 1'b0;
        hold_off                = 1'b0;
        offered_total           = 0;
        accepted_total          = 0;
        error_count             = 0;
        pad_acc_model           = '0;
        cfg_shadow.window_start    = 10'd0;
        cfg_shadow.window_end      = 10'd1023;
        cfg_shadow.peak_mode       = 1'b0;
        cfg_shadow.level_limit     = 20'd1023;
        cfg_shadow.level_threshold = 20'd0;
        cfg_shadow.color_count     = 8'd50;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Print one mismatch line (up to a limit) and count it
    task automatic report_failure(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Palette index: color_count * excess / span, capped at the top entry
    function automatic logic [COLOR_BITS-1:0] palette_for(input logic [ACC_BITS-1:0] level);
        logic [ACC_BITS-1:0] excess;
        longint unsigned     num;
        longint unsigned     den;
        longint unsigned     q;
        if (cfg_shadow.color_count == 0 ||
            cfg_shadow.level_limit <= cfg_shadow.level_threshold)
            return '0;
        excess = level - cfg_shadow.level_threshold;
        num    = longint'(cfg_shadow.color_count) * longint'(excess);
        den    = longint'(cfg_shadow.level_limit - cfg_shadow.level_threshold);
        q      = num / den;
        if (q > longint'(cfg_shadow.color_count) - 1)
            q = longint'(cfg_shadow.color_count) - 1;
        return q[COLOR_BITS-1:0];
    endfunction

    // Fold one sample into the pad accumulator; on the last sample decide the result
    function automatic void integrate_sample(input t_sample s, output bit emit,
                                             output t_pad_result r);
        logic [ACC_BITS:0]   sum;
        logic [ACC_BITS-1:0] addend;
        logic [ACC_BITS-1:0] level;
        logic [WIN_BITS-1:0] span;
        emit = 1'b0;
        r    = '0;
        if (cfg_shadow.peak_mode) begin
            if (ACC_BITS'(s.sample_value) > pad_acc_model)
                pad_acc_model = ACC_BITS'(s.sample_value);
        end else if (s.time_bin >= cfg_shadow.window_start &&
                     s.time_bin <= cfg_shadow.window_end) begin
            span   = cfg_shadow.window_end - cfg_shadow.window_start;
            addend = ACC_BITS'(s.sample_value);
            // Edge bins of an even span count half
            if (!span[0] && (s.time_bin == cfg_shadow.window_start ||
                             s.time_bin == cfg_shadow.window_end))
                addend = ACC_BITS'(s.sample_value >> 1);
            sum = {1'b0, pad_acc_model} + {1'b0, addend};
            pad_acc_model = sum[ACC_BITS] ? ACC_MAX : sum[ACC_BITS-1:0];
        end
        if (s.pad_done) begin
            level = (pad_acc_model < cfg_shadow.level_limit) ? pad_acc_model
                                                             : cfg_shadow.level_limit;
            if (level > cfg_shadow.level_threshold) begin
                emit     = 1'b1;
                r.row    = s.row_index;
                r.column = COL_BITS'(s.pad_index) + COL_BITS'(s.column_offset);
                r.level  = level;
                r.palette = palette_for(level);
            end
            pad_acc_model = '0;
        end
    endfunction

    // Sender: bursts of items with random gaps; predict each item as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_ch.valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) begin
                integrate_sample(offer, offer_emits, offer_result);
                if (offer_emits)
                    pad_results_due.push_back(offer_result);
                accepted_total++;
            end
            if (!sample_ch.valid || sample_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end else if (pending_samples.size() > 0) begin
                    offer = pending_samples.pop_front();
                    sample_ch.valid         <= 1'b1;
                    sample_ch.time_bin      <= offer.time_bin;
                    sample_ch.pad_index     <= offer.pad_index;
                    sample_ch.sample_value  <= offer.sample_value;
                    sample_ch.row_index     <= offer.row_index;
                    sample_ch.column_offset <= offer.column_offset;
                    sample_ch.pad_done      <= offer.pad_done;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   = $urandom_range(0, 6);
                    end
                end else begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switch among stall patterns, and hold off entirely on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_mode  = STALL_NONE;
            mode_left   = 0;
            stall_phase = 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall'($urandom_range(0, 2));
                mode_left  = $urandom_range(20, 200);
            end else begin
                mode_left--;
            end
            stall_phase++;
            case (stall_mode)
                STALL_NONE:   result_ch.ready <= !hold_off;
                STALL_COIN:   result_ch.ready <= !hold_off && ($urandom_range(0, 1) == 1);
                default:      result_ch.ready <= !hold_off && (stall_phase % 4 == 0);
            endcase
        end
    end

    // Long receiver hold-off while the sender keeps offering, to back up the core
    initial begin
        wait (i_rst_n === 1'b1);
        while (accepted_total < HOLD_OFF_AFTER)
            @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // Check each result against the oldest pending pad
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pad_results_due.size() == 0) begin
                report_failure($sformatf("result row %0d col %0d with no pad pending",
                                         result_ch.out_row, result_ch.out_column));
            end else begin
                next_due = pad_results_due.pop_front();
                if (result_ch.out_row !== next_due.row)
                    report_failure($sformatf("out_row expected %0d got %0d",
                                             next_due.row, result_ch.out_row));
                if (result_ch.out_column !== next_due.column)
                    report_failure($sformatf("out_column expected %0d got %0d",
                                             next_due.column, result_ch.out_column));
                if (result_ch.pad_level !== next_due.level)
                    report_failure($sformatf("pad_level expected %0d got %0d",
                                             next_due.level, result_ch.pad_level));
                if (result_ch.palette_index !== next_due.palette)
                    report_failure($sformatf("palette_index expected %0d got %0d",
                                             next_due.palette, result_ch.palette_index));
            end
        end
    end

    task automatic push_sample(input logic [TIME_BITS-1:0] bin,
                               input logic [PAD_BITS-1:0] pad,
                               input logic [VALUE_BITS-1:0] value,
                               input logic [ROW_BITS-1:0] row,
                               input logic [OFF_BITS-1:0] offset,
                               input logic done);
        t_sample s;
        s.time_bin      = bin;
        s.pad_index     = pad;
        s.sample_value  = value;
        s.row_index     = row;
        s.column_offset = offset;
        s.pad_done      = done;
        pending_samples.push_back(s);
        offered_total++;
    endtask

    // Wait until every item is taken and every result is back, then let the tail drain
    task automatic wait_idle();
        while (offered_total != accepted_total || pad_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
    endtask

    // Rewrite all registers once the core is idle, and track them in the predictor
    task automatic apply_config(input logic [WIN_BITS-1:0] start_bin,
                                input logic [WIN_BITS-1:0] end_bin,
                                input logic peak,
                                input logic [ACC_BITS-1:0] limit,
                                input logic [ACC_BITS-1:0] threshold,
                                input logic [COLOR_BITS-1:0] colors);
        wait_idle();
        write_reg(CFG_WINDOW_START,    CFG_DATA_BITS'(start_bin));
        write_reg(CFG_WINDOW_END,      CFG_DATA_BITS'(end_bin));
        write_reg(CFG_PEAK_MODE,       CFG_DATA_BITS'(peak));
        write_reg(CFG_LEVEL_LIMIT,     CFG_DATA_BITS'(limit));
        write_reg(CFG_LEVEL_THRESHOLD, CFG_DATA_BITS'(threshold));
        write_reg(CFG_COLOR_COUNT,     CFG_DATA_BITS'(colors));
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_shadow.window_start    = start_bin;
        cfg_shadow.window_end      = end_bin;
        cfg_shadow.peak_mode       = peak;
        cfg_shadow.level_limit     = limit;
        cfg_shadow.level_threshold = threshold;
        cfg_shadow.color_count     = colors;
    endtask

    // Time bins lean on the window edges and the bins just outside them
    function automatic logic [TIME_BITS-1:0] pick_time();
        logic [TIME_BITS-1:0] lo;
        logic [TIME_BITS-1:0] hi;
        lo = cfg_shadow.window_start;
        hi = cfg_shadow.window_end;
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            2: return lo - 1'b1;
            3: return hi + 1'b1;
            4, 5, 6: begin
                if (lo <= hi)
                    return TIME_BITS'($urandom_range(lo, hi));
                return TIME_BITS'($urandom);
            end
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // Mostly whole pads with random content, some stray items and pads that change index
    task automatic random_traffic(input int n_items);
        int                  added;
        int                  len;
        int                  kind;
        logic [PAD_BITS-1:0] pad;
        logic [ROW_BITS-1:0] row;
        logic [OFF_BITS-1:0] offset;
        added = 0;
        while (added < n_items) begin
            kind   = $urandom_range(0, 9);
            pad    = PAD_BITS'($urandom);
            row    = ROW_BITS'($urandom);
            offset = OFF_BITS'($urandom);
            if (kind == 0) begin
                push_sample(TIME_BITS'($urandom), pad, VALUE_BITS'($urandom), row, offset,
                            1'($urandom));
                added++;
            end else begin
                len = (kind == 9) ? $urandom_range(8, 40) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    if (kind == 1 && i == len / 2)
                        pad = PAD_BITS'($urandom);
                    push_sample(pick_time(), pad, pick_value(), row, offset, i == len - 1);
                end
                added += len;
            end
        end
        // Close whatever pad a stray item left open
        push_sample(pick_time(), PAD_BITS'($urandom), pick_value(), ROW_BITS'($urandom),
                    OFF_BITS'($urandom), 1'b1);
    endtask

    // Stimulus: directed pads first, then random traffic under a series of settings
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // Reset settings: full window, odd span, limit 1023
        push_sample(10'd0, 8'd255, 10'd1023, 8'd255, 9'd511, 1'b1);
        push_sample(10'd1023, 8'd0, 10'd0, 8'd0, 9'd0, 1'b1);
        push_sample(10'd1023, 8'd0, 10'd1, 8'd0, 9'd0, 1'b1);
        push_sample(10'd5, 8'd7, 10'd600, 8'd3, 9'd100, 1'b0);
        push_sample(10'd6, 8'd7, 10'd600, 8'd3, 9'd100, 1'b0);
        push_sample(10'd7, 8'd7, 10'd600, 8'd3, 9'd100, 1'b1);

        // Even span: edge bins count half, bins outside are dropped
        apply_config(10'd10, 10'd20, 1'b0, 20'd1023, 20'd0, 8'd50);
        push_sample(10'd9, 8'd12, 10'd101, 8'd1, 9'd2, 1'b0);
        push_sample(10'd10, 8'd12, 10'd101, 8'd1, 9'd2, 1'b0);
        push_sample(10'd15, 8'd12, 10'd101, 8'd1, 9'd2, 1'b0);
        push_sample(10'd20, 8'd12, 10'd101, 8'd1, 9'd2, 1'b0);
        push_sample(10'd21, 8'd12, 10'd101, 8'd1, 9'd2, 1'b1);

        // Empty window: nothing integrates, nothing is emitted
        apply_config(10'd20, 10'd10, 1'b0, 20'd1023, 20'd0, 8'd50);
        push_sample(10'd15, 8'd3, 10'd900, 8'd4, 9'd5, 1'b0);
        push_sample(10'd20, 8'd3, 10'd900, 8'd4, 9'd5, 1'b1);

        // Peak mode keeps the largest sample
        apply_config(10'd0, 10'd1023, 1'b1, 20'd1023, 20'd0, 8'd50);
        push_sample(10'd100, 8'd9, 10'd5, 8'd6, 9'd7, 1'b0);
        push_sample(10'd900, 8'd9, 10'd900, 8'd6, 9'd7, 1'b0);
        push_sample(10'd3, 8'd9, 10'd300, 8'd6, 9'd7, 1'b1);

        apply_config(10'd0, 10'd1023, 1'b0, 20'd20000, 20'd500, 8'd255);
        random_traffic(180);
        apply_config(10'd100, 10'd400, 1'b0, 20'd4000, 20'd300, 8'd50);
        random_traffic(130);
        apply_config(10'd512, 10'd512, 1'b0, 20'd1023, 20'd100, 8'd16);
        random_traffic(90);
        apply_config(10'd700, 10'd200, 1'b0, 20'd1023, 20'd0, 8'd50);
        random_traffic(30);
        apply_config(10'd0, 10'd1023, 1'b1, 20'd1023, 20'd200, 8'd255);
        random_traffic(120);
        apply_config(10'd300, 10'd301, 1'b1, 20'd800, 20'd0, 8'd1);
        random_traffic(60);
        // Threshold one below the limit: any clamped pad lands on the top entry
        apply_config(10'd0, 10'd1023, 1'b1, 20'd1000, 20'd999, 8'd255);
        random_traffic(30);
        // Zero colors: every palette index is zero
        apply_config(10'd0, 10'd1022, 1'b0, 20'd3000, 20'd10, 8'd0);
        random_traffic(90);
        apply_config(10'd1023, 10'd1023, 1'b0, 20'd0, 20'd0, 8'd8);
        random_traffic(30);
        apply_config(10'd1023, 10'd0, 1'b1, 20'hFFFFF, 20'hFFFFF, 8'd255);
        random_traffic(30);

        // Saturate the accumulator with one long pad of full-scale samples
        apply_config(10'd0, 10'd1023, 1'b0, 20'hFFFFF, 20'd0, 8'd255);
        for (int i = 0; i < 1030; i++)
            push_sample(TIME_BITS'($urandom), 8'd77, 10'd1023, 8'd33, 9'd300, i == 1029);
        random_traffic(60);

        wait_idle();
        if (error_count == 0)
            $display("pad_charge_integrator_core_test passed");
        else
            $display("pad_charge_integrator_core_test failed");
        $finish;
    end

    // Hard stop well past the slowest legitimate run
    initial begin
        #4ms;
        $display("pad_charge_integrator_core_test failed");
        $finish;
    end

endmodule
